// ----- src/ctds_pkg.sv -----
package ctds_pkg;

	localparam int CMD_W       = 2;
	localparam int IDX_W       = 6;
	localparam int OFFS_W      = 19;
	localparam int START_W     = 18;
	localparam int LCS_W       = 4;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 40;
	localparam int OUT_TUSER_W = 2;

	localparam logic [LCS_W-1:0] LCS_MIN   = 4'd2;
	localparam logic [LCS_W-1:0] LCS_MAX   = 4'd12;
	localparam logic [LCS_W-1:0] LCS_RESET = 4'd9;

	typedef enum logic [CMD_W-1:0] {
		CMD_MARK_DIRTY  = 2'd0,
		CMD_SET_TRACE   = 2'd1,
		CMD_CLEAR_TRACE = 2'd2,
		CMD_SCAN        = 2'd3
	} cmd_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;    // input word accepted this cycle
		logic step;    // process the current card
		logic finish;  // load the final word of a scan
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_scan;   // word on the input is a scan command
		logic no_cards;  // scan offset covers no card
		logic at_card0;  // walk is at card zero
		logic out_free;  // output register can take a word this cycle
	} dp_sts_t;

endpackage

// ----- src/ctds_ctrl.sv -----
module ctds_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  ctds_pkg::dp_sts_t   sts,
	output ctds_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_WALK   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d    = state_q;
		s_tready   = 1'b0;
		cmd.take   = 1'b0;
		cmd.step   = 1'b0;
		cmd.finish = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.take = s_tvalid;
				if (s_tvalid && sts.is_scan) begin
					state_d = sts.no_cards ? ST_FINISH : ST_WALK;
				end
			end
			ST_WALK: begin
				// The walk holds while the output register is occupied.
				cmd.step = sts.out_free;
				if (sts.out_free && sts.at_card0) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				cmd.finish = sts.out_free;
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- src/ctds_dp.sv -----
module ctds_dp #(
	parameter int NUM_CARDS = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  ctds_pkg::ctrl_cmd_t                  cmd,
	output ctds_pkg::dp_sts_t                    sts,
	input  logic [ctds_pkg::IN_TDATA_W-1:0]      s_tdata,
	input  logic [ctds_pkg::CMD_W-1:0]           s_tuser,
	input  logic                                 cfg_valid,
	input  logic [ctds_pkg::LCS_W-1:0]           cfg_data,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [ctds_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic [ctds_pkg::OUT_TUSER_W-1:0]     m_tuser,
	output logic                                 m_tlast
);

	localparam int CARD_W = $clog2(NUM_CARDS);
	localparam int OW     = ctds_pkg::OFFS_W;
	localparam int SW     = ctds_pkg::START_W;
	localparam int IW     = ctds_pkg::IDX_W;
	localparam int LW     = ctds_pkg::LCS_W;
	localparam int PADW   = ctds_pkg::OUT_TDATA_W - OW - SW;

	ctds_pkg::cmd_t   in_cmd;
	logic [IW-1:0]    in_idx;
	logic [OW-1:0]    in_trace;
	logic             idx_ok;

	logic [LW-1:0]    lcs_q;
	logic [NUM_CARDS-1:0] dirty_q;
	logic [NUM_CARDS-1:0] trace_q;

	logic [CARD_W-1:0] card_q;
	logic [OW-1:0]     end_q;
	logic              searching_q;

	logic              pend_q;
	logic [SW-1:0]     pend_start_q;
	logic [OW-1:0]     pend_end_q;
	logic              pend_rv_q;
	logic              pend_err_q;

	logic              out_valid_q;
	logic [SW-1:0]     out_start_q;
	logic [OW-1:0]     out_end_q;
	logic              out_rv_q;
	logic              out_err_q;
	logic              out_last_q;

	logic [OW-1:0]     size;
	logic [OW-1:0]     trace_sat;
	logic [OW-1:0]     shifted;
	logic [CARD_W:0]   idx_full;
	logic              rem_zero;
	logic [CARD_W:0]   start_card;

	logic              cur_dirty;
	logic              cur_trace;
	logic              srch;
	logic              hit;
	logic              err_hit;
	logic [SW-1:0]     card_start;
	logic              out_free;
	logic              push_pend;

	assign in_cmd   = ctds_pkg::cmd_t'(s_tuser);
	assign in_idx   = s_tdata[IW-1:0];
	assign in_trace = s_tdata[IW +: OW];
	assign idx_ok   = ((IW+1)'(in_idx) < (IW+1)'(NUM_CARDS));

	// Start card of a scan: the card holding the last address below the offset.
	assign size       = OW'(NUM_CARDS) << lcs_q;
	assign trace_sat  = (in_trace > size) ? size : in_trace;
	assign shifted    = trace_sat >> lcs_q;
	assign idx_full   = shifted[CARD_W:0];
	assign rem_zero   = ((trace_sat & ((OW'(1) << lcs_q) - OW'(1))) == '0);
	assign start_card = idx_full - (CARD_W+1)'(rem_zero);

	assign cur_dirty  = dirty_q[card_q];
	assign cur_trace  = trace_q[card_q];
	assign srch       = searching_q | cur_dirty;
	assign hit        = srch & cur_trace;
	assign err_hit    = srch & ~cur_trace & (card_q == '0);
	assign card_start = SW'(card_q) << lcs_q;
	assign out_free   = ~out_valid_q | m_tready;

	// A newly found item pushes the held one out; the held word waits so that
	// the final word of a scan can carry the last flag.
	assign push_pend  = cmd.step & (hit | err_hit) & pend_q;

	assign sts.is_scan  = (in_cmd == ctds_pkg::CMD_SCAN);
	assign sts.no_cards = (idx_full == '0) & rem_zero;
	assign sts.at_card0 = (card_q == '0);
	assign sts.out_free = out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lcs_q <= ctds_pkg::LCS_RESET;
		end else if (cfg_valid) begin
			if (cfg_data < ctds_pkg::LCS_MIN) begin
				lcs_q <= ctds_pkg::LCS_MIN;
			end else if (cfg_data > ctds_pkg::LCS_MAX) begin
				lcs_q <= ctds_pkg::LCS_MAX;
			end else begin
				lcs_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= '0;
			trace_q <= '0;
		end else begin
			if (cmd.take) begin
				case (in_cmd)
					ctds_pkg::CMD_MARK_DIRTY: begin
						if (idx_ok) begin
							dirty_q[in_idx[CARD_W-1:0]] <= 1'b1;
						end
					end
					ctds_pkg::CMD_SET_TRACE: begin
						if (idx_ok) begin
							trace_q[in_idx[CARD_W-1:0]] <= 1'b1;
						end
					end
					ctds_pkg::CMD_CLEAR_TRACE: begin
						trace_q <= '0;
					end
					default: begin
					end
				endcase
			end
			if (cmd.step) begin
				dirty_q[card_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			searching_q <= 1'b0;
			pend_q      <= 1'b0;
		end else begin
			if (cmd.take && sts.is_scan) begin
				searching_q <= 1'b0;
				pend_q      <= 1'b0;
			end else if (cmd.step) begin
				searching_q <= srch & ~cur_trace;
				if (hit || err_hit) begin
					pend_q <= 1'b1;
				end
			end else if (cmd.finish) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take && sts.is_scan) begin
			card_q <= start_card[CARD_W-1:0];
			end_q  <= trace_sat;
		end else if (cmd.step) begin
			if (card_q != '0) begin
				card_q <= card_q - CARD_W'(1);
			end
			if (hit) begin
				end_q        <= OW'(card_start);
				pend_start_q <= card_start;
				pend_end_q   <= end_q;
				pend_rv_q    <= 1'b1;
				pend_err_q   <= 1'b0;
			end else if (err_hit) begin
				pend_start_q <= '0;
				pend_end_q   <= '0;
				pend_rv_q    <= 1'b0;
				pend_err_q   <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push_pend || cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_pend) begin
			out_start_q <= pend_start_q;
			out_end_q   <= pend_end_q;
			out_rv_q    <= pend_rv_q;
			out_err_q   <= pend_err_q;
			out_last_q  <= 1'b0;
		end else if (cmd.finish) begin
			out_last_q <= 1'b1;
			if (pend_q) begin
				out_start_q <= pend_start_q;
				out_end_q   <= pend_end_q;
				out_rv_q    <= pend_rv_q;
				out_err_q   <= pend_err_q;
			end else begin
				out_start_q <= '0;
				out_end_q   <= '0;
				out_rv_q    <= 1'b0;
				out_err_q   <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PADW{1'b0}}, out_end_q, out_start_q};
	assign m_tuser  = {out_err_q, out_rv_q};
	assign m_tlast  = out_last_q;

endmodule

// ----- src/card_table_dirty_scan.sv -----
// Card table with a dirty and a traceable bit per card. Mark dirty, set
// traceable and clear traceable are each taken while idle. A scan is
// accepted, then walks one card per cycle from the start card down to card
// zero in a single shared step unit, and then loads its final word; with a
// zero offset it goes straight to the final word. The walk holds in any cycle
// in which the output register still has a word that has not been taken.
// Each range word is held back by one found range so that the final word of a
// scan carries tlast; an error word is always the last.
module card_table_dirty_scan #(
	parameter int NUM_CARDS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,   // log_card_size
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,    // [5:0] card_index, [24:6] trace_offset, rest zero
	input  logic [1:0]  s_tuser,    // [1:0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,    // [17:0] range_start, [36:18] range_end, rest zero
	output logic [1:0]  m_tuser,    // [0] range_valid, [1] not_traceable_error
	output logic        m_tlast
);

	ctds_pkg::ctrl_cmd_t cmd;
	ctds_pkg::dp_sts_t   sts;

	assign cfg_ready = 1'b1;

	ctds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	ctds_dp #(
		.NUM_CARDS (NUM_CARDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// ----- tb/sv/card_table_dirty_scan_chk.sv -----
`timescale 1ns / 100ps

module card_table_dirty_scan_chk #(
	parameter int NUM_CARDS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,    // [5:0] card_index, [24:6] trace_offset, rest zero
	input  logic [1:0]  s_tuser,    // [1:0] command
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,    // [17:0] range_start, [36:18] range_end, rest zero
	input  logic [1:0]  m_tuser,    // [0] range_valid, [1] not_traceable_error
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending,
	output int          range_count,
	output int          error_count,
	output int          empty_count
);

	typedef struct packed {
		logic [17:0] range_start;
		logic [18:0] range_end;
		logic        range_valid;
		logic        not_traceable_error;
		logic        last;
	} range_word_t;

	bit                         card_dirty [NUM_CARDS];
	bit                         card_traceable [NUM_CARDS];
	logic [ctds_pkg::LCS_W-1:0] card_shift;
	range_word_t                pending_ranges [$];
	range_word_t                want;
	range_word_t                seen;

	task automatic push_range(input int unsigned start, input int unsigned stop,
			input bit valid, input bit err, input bit last);
		range_word_t w;
		w.range_start         = start[17:0];
		w.range_end           = stop[18:0];
		w.range_valid         = valid;
		w.not_traceable_error = err;
		w.last                = last;
		pending_ranges.push_back(w);
	endtask

	// Updates the card table for one input word and queues the words a scan yields.
	task automatic apply_command(input ctds_pkg::cmd_t cmd, input logic [5:0] idx,
			input logic [18:0] offs);
		int unsigned area;
		int unsigned card_mask;
		int unsigned trace;
		int unsigned run_end;
		int          c;
		bit          seeking;
		bit          hit_error;
		int          produced;
		range_word_t w;
		case (cmd)
			ctds_pkg::CMD_MARK_DIRTY: begin
				if (idx < NUM_CARDS)
					card_dirty[idx] = 1'b1;
			end
			ctds_pkg::CMD_SET_TRACE: begin
				if (idx < NUM_CARDS)
					card_traceable[idx] = 1'b1;
			end
			ctds_pkg::CMD_CLEAR_TRACE: begin
				foreach (card_traceable[k])
					card_traceable[k] = 1'b0;
			end
			default: begin
				area      = NUM_CARDS << card_shift;
				card_mask = (1 << card_shift) - 1;
				trace     = (offs > area) ? area : offs;
				c         = trace >> card_shift;
				// An offset on a card boundary belongs to the card below.
				if ((trace & card_mask) == 0)
					c = c - 1;
				run_end   = trace;
				seeking   = 1'b0;
				hit_error = 1'b0;
				produced  = 0;
				while (c >= 0 && !hit_error) begin
					if (card_dirty[c]) begin
						card_dirty[c] = 1'b0;
						seeking       = 1'b1;
					end
					if (seeking) begin
						if (card_traceable[c]) begin
							push_range(c << card_shift, run_end, 1'b1, 1'b0, 1'b0);
							run_end  = c << card_shift;
							seeking  = 1'b0;
							produced = produced + 1;
						end else if (c == 0) begin
							push_range(0, 0, 1'b0, 1'b1, 1'b1);
							hit_error = 1'b1;
						end
					end
					c = c - 1;
				end
				if (!hit_error) begin
					if (produced == 0) begin
						push_range(0, 0, 1'b0, 1'b0, 1'b1);
					end else begin
						w      = pending_ranges.pop_back();
						w.last = 1'b1;
						pending_ranges.push_back(w);
					end
				end
			end
		endcase
	endtask

	task automatic compare_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, act_v);
			fail_count = fail_count + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (card_dirty[k]) begin
				card_dirty[k]     = 1'b0;
				card_traceable[k] = 1'b0;
			end
			card_shift  = ctds_pkg::LCS_RESET;
			pending_ranges.delete();
			fail_count  = 0;
			pending     = 0;
			range_count = 0;
			error_count = 0;
			empty_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				seen.range_start         = m_tdata[17:0];
				seen.range_end           = m_tdata[36:18];
				seen.range_valid         = m_tuser[0];
				seen.not_traceable_error = m_tuser[1];
				seen.last                = m_tlast;
				if (seen.range_valid)
					range_count = range_count + 1;
				else if (seen.not_traceable_error)
					error_count = error_count + 1;
				else
					empty_count = empty_count + 1;
				if (pending_ranges.size() == 0) begin
					$error("output word with no word expected: tdata %h tuser %b tlast %b",
						m_tdata, m_tuser, m_tlast);
					fail_count = fail_count + 1;
				end else begin
					want = pending_ranges.pop_front();
					compare_field("range_start", want.range_start, seen.range_start);
					compare_field("range_end", want.range_end, seen.range_end);
					compare_field("range_valid", want.range_valid, seen.range_valid);
					compare_field("not_traceable_error", want.not_traceable_error,
						seen.not_traceable_error);
					compare_field("last", want.last, seen.last);
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_data < ctds_pkg::LCS_MIN)
					card_shift = ctds_pkg::LCS_MIN;
				else if (cfg_data > ctds_pkg::LCS_MAX)
					card_shift = ctds_pkg::LCS_MAX;
				else
					card_shift = cfg_data;
			end
			if (s_tvalid && s_tready)
				apply_command(ctds_pkg::cmd_t'(s_tuser), s_tdata[5:0], s_tdata[24:6]);
			pending = pending_ranges.size();
		end
	end

endmodule

// ----- tb/sv/card_table_dirty_scan_tb.sv -----
`timescale 1ns / 100ps

module card_table_dirty_scan_tb;

	localparam int NUM_CARDS   = 64;
	localparam int SETTLE      = 80;
	localparam int DRAIN_LIMIT = 50000;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;    // [5:0] card_index, [24:6] trace_offset, rest zero
	logic [1:0]  s_tuser;    // [1:0] command
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;    // [17:0] range_start, [36:18] range_end, rest zero
	logic [1:0]  m_tuser;    // [0] range_valid, [1] not_traceable_error
	logic        m_tlast;

	int fail_count;
	int pending;
	int range_count;
	int error_count;
	int empty_count;

	bit                         steady;
	bit                         hold_req;
	int                         hold_left;
	int                         words_sent;
	int                         drain_fail;
	int                         settings_seen;
	logic [ctds_pkg::LCS_W-1:0] lcs_now;

	card_table_dirty_scan #(
		.NUM_CARDS(NUM_CARDS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	card_table_dirty_scan_chk #(
		.NUM_CARDS(NUM_CARDS)
	) u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.fail_count (fail_count),
		.pending    (pending),
		.range_count(range_count),
		.error_count(error_count),
		.empty_count(empty_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// Output side: random back-pressure, plus one long hold-off on request.
	initial begin
		m_tready  = 1'b0;
		hold_left = 0;
		forever @(negedge clk) begin
			if (hold_left > 0) begin
				m_tready  = 1'b0;
				hold_left = hold_left - 1;
			end else if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = 299;
				m_tready  = 1'b0;
			end else begin
				m_tready = steady || ($urandom_range(99) >= 13);
			end
		end
	end

	task automatic send_word(input ctds_pkg::cmd_t cmd, input logic [5:0] idx,
			input logic [18:0] offs);
		while (!steady && $urandom_range(99) < 13) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = cmd;
		s_tdata  = {7'd0, offs, idx};
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
		words_sent = words_sent + 1;
	endtask

	// Waits until every expected word has come, then lets the block settle.
	task automatic wait_idle;
		int spins;
		s_tvalid = 1'b0;
		spins    = 0;
		while (pending != 0 && spins < DRAIN_LIMIT) begin
			@(negedge clk);
			spins = spins + 1;
		end
		if (pending != 0) begin
			$error("%0d expected words never arrived", pending);
			drain_fail = drain_fail + 1;
		end
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_lcs(input logic [3:0] value);
		wait_idle();
		cfg_valid = 1'b1;
		cfg_data  = value;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		if (value < ctds_pkg::LCS_MIN)
			lcs_now = ctds_pkg::LCS_MIN;
		else if (value > ctds_pkg::LCS_MAX)
			lcs_now = ctds_pkg::LCS_MAX;
		else
			lcs_now = value;
		settings_seen = settings_seen + 1;
	endtask

	function automatic logic [18:0] pick_offset();
		int unsigned area;
		int unsigned v;
		area = NUM_CARDS << lcs_now;
		case ($urandom_range(9))
			0: v = 0;
			1: v = area;
			2: v = $urandom_range(NUM_CARDS) << lcs_now;
			3: v = $urandom & 32'h7FFFF;
			4: v = area + $urandom_range(1, 300);
			default: v = $urandom_range(1, area);
		endcase
		return v[18:0];
	endfunction

	task automatic random_words(input int count);
		int             r;
		ctds_pkg::cmd_t cmd;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 35)
				cmd = ctds_pkg::CMD_MARK_DIRTY;
			else if (r < 62)
				cmd = ctds_pkg::CMD_SET_TRACE;
			else if (r < 66)
				cmd = ctds_pkg::CMD_CLEAR_TRACE;
			else
				cmd = ctds_pkg::CMD_SCAN;
			send_word(cmd, 6'($urandom_range(NUM_CARDS - 1)), pick_offset());
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = 4'd0;
		s_tvalid      = 1'b0;
		s_tdata       = 32'd0;
		s_tuser       = ctds_pkg::CMD_MARK_DIRTY;
		steady        = 1'b0;
		hold_req      = 1'b0;
		words_sent    = 0;
		drain_fail    = 0;
		settings_seen = 1;
		lcs_now       = ctds_pkg::LCS_RESET;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed words at the reset card size of 512.
		send_word(ctds_pkg::CMD_SCAN, 6'd0, 19'd0);
		send_word(ctds_pkg::CMD_SCAN, 6'd0, 19'h7FFFF);
		send_word(ctds_pkg::CMD_MARK_DIRTY, 6'd63, 19'd0);
		send_word(ctds_pkg::CMD_SET_TRACE, 6'd0, 19'd0);
		send_word(ctds_pkg::CMD_SET_TRACE, 6'd40, 19'd0);
		send_word(ctds_pkg::CMD_MARK_DIRTY, 6'd0, 19'd0);
		send_word(ctds_pkg::CMD_MARK_DIRTY, 6'd45, 19'd0);
		send_word(ctds_pkg::CMD_SCAN, 6'd0, 19'd262144);
		send_word(ctds_pkg::CMD_MARK_DIRTY, 6'd5, 19'd0);
		send_word(ctds_pkg::CMD_CLEAR_TRACE, 6'd0, 19'd0);
		send_word(ctds_pkg::CMD_SCAN, 6'd0, 19'd3072);
		send_word(ctds_pkg::CMD_MARK_DIRTY, 6'd10, 19'd0);
		send_word(ctds_pkg::CMD_SET_TRACE, 6'd10, 19'd0);
		send_word(ctds_pkg::CMD_SCAN, 6'd0, 19'd5120);
		send_word(ctds_pkg::CMD_SCAN, 6'd0, 19'd5121);
		// A found range followed by a search that runs off card zero.
		send_word(ctds_pkg::CMD_MARK_DIRTY, 6'd20, 19'd0);
		send_word(ctds_pkg::CMD_SET_TRACE, 6'd20, 19'd0);
		send_word(ctds_pkg::CMD_MARK_DIRTY, 6'd3, 19'd0);
		send_word(ctds_pkg::CMD_SCAN, 6'd0, 19'd10340);

		write_lcs(4'd12);
		random_words(11);

		// Smallest cards; the receiver stops for a while so the block backs up.
		write_lcs(4'd2);
		hold_req = 1'b1;
		for (int k = 0; k < 8; k++)
			send_word(ctds_pkg::CMD_SET_TRACE, 6'(k * 8), 19'd0);
		repeat (4) begin
			for (int k = 0; k < 4; k++)
				send_word(ctds_pkg::CMD_MARK_DIRTY, 6'(k * 16 + 5), 19'd0);
			send_word(ctds_pkg::CMD_SCAN, 6'd0, 19'(NUM_CARDS << lcs_now));
		end
		random_words(11);

		write_lcs(4'd15);
		steady = 1'b1;
		random_words(20);
		steady = 1'b0;

		write_lcs(4'd0);
		random_words(11);

		write_lcs(4'd7);
		random_words(11);

		wait_idle();
		$display("Sent %0d input words under %0d card sizes.", words_sent, settings_seen);
		$display("Scans gave %0d ranges, %0d card-zero errors and %0d empty results.",
			range_count, error_count, empty_count);
		if (fail_count == 0 && drain_fail == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
